// File: rtl/core/pst_pkg.sv
package pst_pkg;

    localparam int MAX_JOBS_DEF = 32;

    typedef struct packed {
        logic [15:0] burst_time;
        logic [7:0]  priority_req;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic        row_kind;
        logic [5:0]  job_number;
        logic [15:0] job_burst;
        logic [7:0]  job_priority;
        logic [20:0] turnaround;
        logic [20:0] waiting;
        logic [25:0] total_turnaround;
        logic [20:0] avg_turnaround;
        logic [25:0] total_waiting;
        logic [20:0] avg_waiting;
        logic        overflow;
        logic        last_result;
    } t_out_item;

    // one memory word: burst, priority, arrival number
    typedef struct packed {
        logic [15:0] burst;
        logic [7:0]  pri;
        logic [5:0]  num;
    } t_job;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD_I,
        ST_RD_J,
        ST_CMP,
        ST_WR_I,
        ST_NEXT_J,
        ST_EMIT_RD,
        ST_EMIT,
        ST_DIV,
        ST_SUM
    } t_state;

endpackage

// File: rtl/core/priority_schedule_timing.sv
// Nonpreemptive priority scheduler. Each job item is taken while start is
// high and busy is low; the item with last set closes the set, and busy stays
// high until the cycle in which the summary row is on o_result. Jobs live in
// one single-port-write, single-read synchronous memory. The exchange sort
// runs over it: each outer pass reloads a[i], each pair is read and compared,
// and a swap writes a[j] and then a[i]. Job rows go out one per cycle. Two
// 26-bit restoring divisions run side by side, one quotient bit per cycle,
// after the last job row. Each row comes with o_strobe high for a single
// cycle; the receiver cannot stall. o_result.overflow is set on every row of
// a set that lost jobs. busy is high while reset is asserted.
module priority_schedule_timing
    #(
        parameter int MAX_JOBS = pst_pkg::MAX_JOBS_DEF
    )
    (
        input  logic               i_clk,
        input  logic               i_rst_n,
        input  logic               start,
        output logic               busy,
        input  pst_pkg::t_in_item  i_item,
        output logic               o_strobe,
        output pst_pkg::t_out_item o_result
    );
    import pst_pkg::*;

    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int SW = 26;

    t_job r_mem [MAX_JOBS];
    t_job r_rd;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_job          w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    t_job          r_a, n_a;
    logic [20:0]   r_el, n_el;
    logic [SW-1:0] r_tt, n_tt, r_tw, n_tw;
    logic [SW-1:0] r_qt, n_qt, r_qw, n_qw;
    logic [SW-1:0] r_rt, n_rt, r_rw, n_rw;
    logic [4:0]    r_bit, n_bit;
    logic          r_stb, n_stb;
    t_out_item     r_out, n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_stb   <= n_stb;
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_a   <= n_a;
        r_el  <= n_el;
        r_tt  <= n_tt;
        r_tw  <= n_tw;
        r_qt  <= n_qt;
        r_qw  <= n_qw;
        r_rt  <= n_rt;
        r_rw  <= n_rw;
        r_bit <= n_bit;
        r_out <= n_out;
    end

    logic [SW:0]   w_trt, w_trw;
    logic [SW-1:0] w_den;
    logic [20:0]   w_el;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_drop  = r_drop;
        n_i     = r_i;
        n_j     = r_j;
        n_a     = r_a;
        n_el    = r_el;
        n_tt    = r_tt;
        n_tw    = r_tw;
        n_qt    = r_qt;
        n_qw    = r_qw;
        n_rt    = r_rt;
        n_rw    = r_rw;
        n_bit   = r_bit;
        n_stb   = 1'b0;
        n_out   = r_out;
        w_raddr = r_i[AW-1:0];
        w_we    = 1'b0;
        w_waddr = r_cnt[AW-1:0];
        w_wdata = r_a;
        busy    = 1'b1;
        w_den   = SW'(r_cnt);
        w_trt   = {r_rt, r_qt[SW-1]} - {1'b0, w_den};
        w_trw   = {r_rw, r_qw[SW-1]} - {1'b0, w_den};
        w_el    = r_el + 21'(r_rd.burst);

        case (r_state)
            ST_LOAD: begin
                busy = !i_rst_n;
                if (start) begin
                    if (r_cnt < CW'(MAX_JOBS)) begin
                        w_we    = 1'b1;
                        w_waddr = r_cnt[AW-1:0];
                        w_wdata = '{burst: i_item.burst_time, pri: i_item.priority_req,
                                    num: 6'(r_cnt + 1'b1)};
                        n_cnt   = r_cnt + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_item.last) begin
                        n_i     = '0;
                        n_state = ST_RD_I;
                    end
                end
            end
            ST_RD_I: begin
                // reload a[i] each outer pass; j starts past i
                w_raddr = r_i[AW-1:0];
                n_j     = r_i + 1'b1;
                if (r_i + 1'b1 >= n_cnt) begin
                    n_i     = '0;
                    n_el    = '0;
                    n_tt    = '0;
                    n_tw    = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_RD_J;
                end
            end
            ST_RD_J: begin
                if (r_j == r_i + 1'b1) begin
                    n_a = r_rd;
                end
                w_raddr = r_j[AW-1:0];
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_a.pri > r_rd.pri) begin
                    // a[j] <= held a[i]; held copy becomes old a[j]
                    w_we    = 1'b1;
                    w_waddr = r_j[AW-1:0];
                    w_wdata = r_a;
                    n_a     = r_rd;
                    n_state = ST_WR_I;
                end else begin
                    n_state = ST_NEXT_J;
                end
            end
            ST_WR_I: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = r_a;
                n_state = ST_NEXT_J;
            end
            ST_NEXT_J: begin
                if (r_j + 1'b1 >= r_cnt) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_RD_I;
                end else begin
                    n_j     = r_j + 1'b1;
                    w_raddr = n_j[AW-1:0];
                    n_state = ST_CMP;
                end
            end
            ST_EMIT_RD: begin
                w_raddr = r_i[AW-1:0];
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_el  = w_el;
                n_tt  = r_tt + SW'(w_el);
                n_tw  = r_tw + SW'(r_el);
                n_stb = 1'b1;
                n_out = '0;
                n_out.job_number   = r_rd.num;
                n_out.job_burst    = r_rd.burst;
                n_out.job_priority = r_rd.pri;
                n_out.turnaround   = w_el;
                n_out.waiting      = r_el;
                n_out.overflow     = r_drop;
                n_i = r_i + 1'b1;
                if (r_i + 1'b1 >= r_cnt) begin
                    n_qt    = n_tt;
                    n_qw    = n_tw;
                    n_rt    = '0;
                    n_rw    = '0;
                    n_bit   = 5'(SW - 1);
                    n_state = ST_DIV;
                end else begin
                    w_raddr = n_i[AW-1:0];
                    n_state = ST_EMIT;
                end
            end
            ST_DIV: begin
                // restoring division, dividend shifts out of q as quotient shifts in
                if (!w_trt[SW]) begin
                    n_rt = w_trt[SW-1:0];
                    n_qt = {r_qt[SW-2:0], 1'b1};
                end else begin
                    n_rt = {r_rt[SW-2:0], r_qt[SW-1]};
                    n_qt = {r_qt[SW-2:0], 1'b0};
                end
                if (!w_trw[SW]) begin
                    n_rw = w_trw[SW-1:0];
                    n_qw = {r_qw[SW-2:0], 1'b1};
                end else begin
                    n_rw = {r_rw[SW-2:0], r_qw[SW-1]};
                    n_qw = {r_qw[SW-2:0], 1'b0};
                end
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_stb = 1'b1;
                n_out = '0;
                n_out.row_kind         = 1'b1;
                n_out.total_turnaround = r_tt;
                n_out.total_waiting    = r_tw;
                n_out.avg_turnaround   = (r_cnt == '0) ? '0 : r_qt[20:0];
                n_out.avg_waiting      = (r_cnt == '0) ? '0 : r_qw[20:0];
                n_out.overflow         = r_drop;
                n_out.last_result      = 1'b1;
                n_cnt   = '0;
                n_drop  = 1'b0;
                n_state = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_strobe = r_stb;
    assign o_result = r_out;

endmodule

// File: rtl/core/pst_checker.sv
module pst_checker
    (
        input logic               i_clk,
        input logic               i_rst_n,
        input logic               start,
        input logic               busy,
        input logic               o_strobe,
        input pst_pkg::t_out_item o_result
    );
    import pst_pkg::*;

    // a set closes with its summary row, and then the block is free again
    a_sum_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_result) |-> !busy)
        else $error("summary row while still busy");

    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.row_kind == o_result.last_result))
        else $error("row kind and last flag disagree");

    a_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("row right after an accepted item");

    a_job_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.row_kind) |-> (o_result.job_number != 6'd0))
        else $error("job row without arrival number");

endmodule

bind priority_schedule_timing pst_checker u_pst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// File: bench/priority_schedule_timing_tb.sv
`timescale 1ns / 1ps

module priority_schedule_timing_tb;
    import pst_pkg::*;

    localparam int NJOBS = MAX_JOBS_DEF;
    localparam int WATCHDOG = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   i_item;
    logic       o_strobe;
    t_out_item  o_result;

    priority_schedule_timing uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_result(o_result)
    );

    // scheduler shadow state
    logic [15:0] sh_burst [NJOBS];
    logic [7:0]  sh_pri   [NJOBS];
    logic [5:0]  sh_num   [NJOBS];
    int          sh_count = 0;
    logic        sh_dropped = 1'b0;

    t_in_item  pending_jobs[$];
    int        pending_gap[$];
    t_out_item expected_rows[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        timed_out = 1'b0;
    bit        hold_for_drain = 1'b0;
    bit        acc_seen = 1'b0;
    int        gap_left = -1;

    task automatic schedule_job(input t_in_item it);
        logic [15:0] tb;
        logic [7:0]  tp;
        logic [5:0]  tn;
        logic [25:0] elapsed, tot_tat, tot_wt;
        t_out_item   row;
        if (sh_count < NJOBS) begin
            sh_burst[sh_count] = it.burst_time;
            sh_pri[sh_count] = it.priority_req;
            sh_num[sh_count] = 6'(sh_count + 1);
            sh_count++;
        end else begin
            sh_dropped = 1'b1;
        end
        if (!it.last) return;
        // unstable exchange sort, same pair order as the block
        for (int i = 0; i < sh_count; i++)
            for (int j = i + 1; j < sh_count; j++)
                if (sh_pri[i] > sh_pri[j]) begin
                    tb = sh_burst[i]; sh_burst[i] = sh_burst[j]; sh_burst[j] = tb;
                    tp = sh_pri[i]; sh_pri[i] = sh_pri[j]; sh_pri[j] = tp;
                    tn = sh_num[i]; sh_num[i] = sh_num[j]; sh_num[j] = tn;
                end
        elapsed = 0; tot_tat = 0; tot_wt = 0;
        for (int i = 0; i < sh_count; i++) begin
            row = '0;
            row.job_number = sh_num[i];
            row.job_burst = sh_burst[i];
            row.job_priority = sh_pri[i];
            row.waiting = 21'(elapsed);
            tot_wt += elapsed;
            elapsed += sh_burst[i];
            tot_tat += elapsed;
            row.turnaround = 21'(elapsed);
            row.overflow = sh_dropped;
            expected_rows.push_back(row);
        end
        row = '0;
        row.row_kind = 1'b1;
        row.total_turnaround = tot_tat;
        row.total_waiting = tot_wt;
        if (sh_count != 0) begin
            row.avg_turnaround = 21'(tot_tat / sh_count);
            row.avg_waiting = 21'(tot_wt / sh_count);
        end
        row.overflow = sh_dropped;
        row.last_result = 1'b1;
        expected_rows.push_back(row);
        sh_count = 0;
        sh_dropped = 1'b0;
    endtask

    function automatic int draw_gap();
        // about a third of items go back to back
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic add_job(input logic [15:0] b, input logic [7:0] p, input logic l);
        t_in_item it;
        it.burst_time = b;
        it.priority_req = p;
        it.last = l;
        pending_jobs.push_back(it);
        pending_gap.push_back(draw_gap());
    endtask

    task automatic add_random_set(input int n);
        logic [7:0] pmax;
        pmax = ($urandom_range(0, 1) == 0) ? 8'd3 : 8'd255;
        for (int k = 0; k < n; k++)
            add_job(16'($urandom_range(0, 65535)), 8'($urandom_range(0, pmax)),
                    k == n - 1);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // driver: each item waits out its gap, then stays presented until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_item <= '0;
            gap_left = -1;
        end else if (start && !acc_seen) begin
            // hold the item until taken
        end else if (pending_jobs.size() == 0 ||
                     (hold_for_drain && expected_rows.size() != 0)) begin
            start <= 1'b0;
        end else begin
            if (gap_left < 0) gap_left = pending_gap.pop_front();
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else begin
                i_item <= pending_jobs[0];
                start <= 1'b1;
                gap_left = -1;
            end
        end
    end

    // acceptance and checking at the rising edge
    always @(posedge i_clk) begin
        acc_seen = i_rst_n && start && !busy;
        if (i_rst_n) begin
            idle_cycles++;
            if (acc_seen) begin
                idle_cycles = 0;
                schedule_job(i_item);
                void'(pending_jobs.pop_front());
            end
            if (o_strobe) begin
                idle_cycles = 0;
                if (expected_rows.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected row %p", o_result);
                end else begin
                    if (o_result !== expected_rows[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("row mismatch: expected %p actual %p",
                                     expected_rows[0], o_result);
                    end
                    void'(expected_rows.pop_front());
                end
            end
            if (idle_cycles >= WATCHDOG) timed_out = 1'b1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single jobs at extremes
        add_job(16'hFFFF, 8'hFF, 1'b1);
        add_job(16'h0000, 8'h00, 1'b1);
        // ties and mixed priorities
        add_job(16'd10, 8'd5, 1'b0);
        add_job(16'd20, 8'd5, 1'b0);
        add_job(16'd30, 8'd1, 1'b0);
        add_job(16'd40, 8'd9, 1'b1);
        add_job(16'hAAAA, 8'h55, 1'b0);
        add_job(16'h5555, 8'hAA, 1'b1);
        // full store, then dropped items, the last of them closing the set
        for (int k = 0; k < NJOBS + 2; k++)
            add_job(16'hFFFF, 8'(NJOBS - k), k == NJOBS + 1);

        for (int k = 0; k < 20; k++) add_random_set($urandom_range(1, 5));
        // a random set that overflows
        add_random_set(NJOBS + 1 + $urandom_range(0, 2));

        // once, keep the sender quiet until every pending row is out
        fork
            begin
                wait (pending_jobs.size() < 40);
                wait (expected_rows.size() != 0);
                hold_for_drain = 1'b1;
                wait (expected_rows.size() == 0);
                hold_for_drain = 1'b0;
            end
        join_none

        wait (timed_out || (pending_jobs.size() == 0 && expected_rows.size() == 0));
        if (!timed_out) begin
            repeat (200) @(posedge i_clk);
            if (mismatches == 0 && expected_rows.size() == 0) $display("tb: success");
            else $display("tb: failure");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
